// ----- src/bba_pkg.sv -----
// Shared types and constants of the buddy block allocator.
// Depends on nothing; every other file of the block but bba_ram uses it.
package bba_pkg;

  localparam int LEVELS_W  = 4;
  localparam int BUCKET_W  = 13;
  localparam int ADDR_W    = 32;
  localparam int REQ_W     = 24;
  localparam int STATUS_W  = 2;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [LEVELS_W-1:0] LEVELS_RST = 4'd11;
  localparam logic [BUCKET_W-1:0] BUCKET_RST = 13'd64;
  localparam logic [ADDR_W-1:0]   BASE_RST   = 32'd0;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LVL, S_SINIT, S_SRD, S_SCHK, S_GRAB, S_SPLIT, S_TAKE,
    S_ADDR, S_FCHK, S_DIV, S_CRD, S_CCHK, S_UNTAKE, S_MRD, S_MCHK, S_MSET, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LATCH, OP_LVL_DEC, OP_FAIL_SPACE, OP_FAIL_FREE,
    OP_SCAN_INIT, OP_RD_FREE, OP_NEXT_NODE, OP_NEXT_LEVEL, OP_GRAB, OP_SPLIT,
    OP_TAKE, OP_ADDR, OP_DIV_INIT, OP_DIV_STEP, OP_LEAF, OP_RD_TAKEN, OP_CLIMB,
    OP_UNTAKE, OP_RD_BUD, OP_MERGE, OP_MSET
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic lvl_fit;
    logic lvl_is_one;
    logic mem_bit;
    logic level_end;
    logic k_is_one;
    logic k_at_target;
    logic off_outside;
    logic div_done;
    logic node_is_root;
  } flags_t;

endpackage

// ----- src/bba_req_if.sv -----
// Request channel of the buddy block allocator: handshake plus request fields.
// Depends on bba_pkg for the field widths.
interface bba_req_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [bba_pkg::REQ_W-1:0]    request_bytes;
  logic [bba_pkg::ADDR_W-1:0]   release_address;

  modport source (output valid, action, request_bytes, release_address, input ready);
  modport sink   (input valid, action, request_bytes, release_address, output ready);
endinterface

// ----- src/bba_rsp_if.sv -----
// Result channel of the buddy block allocator: handshake plus result fields.
// Depends on bba_pkg for the field widths.
interface bba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bba_pkg::STATUS_W-1:0]  status;
  logic [bba_pkg::ADDR_W-1:0]    block_address;

  modport source (output valid, status, block_address, input ready);
  modport sink   (input valid, status, block_address, output ready);
endinterface

// ----- src/bba_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2047
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ----- src/bba_ctrl.sv -----
// Controller state machine of the buddy block allocator.
// Depends on bba_pkg; drives the datapath through cmd_t and reads flags_t.
module bba_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_action,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  bba_pkg::flags_t flags,
  output bba_pkg::cmd_t   cmd
);
  import bba_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (flags.clear_done) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = (in_action == ACT_FREE) ? S_FCHK : S_LVL;
      S_LVL: begin
        if (flags.lvl_fit) state_next = S_SINIT;
        else if (flags.lvl_is_one) state_next = S_DONE;
      end
      S_SINIT:  state_next = S_SRD;
      S_SRD:    state_next = S_SCHK;
      S_SCHK: begin
        if (flags.mem_bit) state_next = S_GRAB;
        else if (flags.level_end && flags.k_is_one) state_next = S_DONE;
        else state_next = S_SRD;
      end
      S_GRAB:   state_next = S_SPLIT;
      S_SPLIT:  if (flags.k_at_target) state_next = S_TAKE;
      S_TAKE:   state_next = S_ADDR;
      S_ADDR:   state_next = S_DONE;
      S_FCHK:   state_next = flags.off_outside ? S_DONE : S_DIV;
      S_DIV:    if (flags.div_done) state_next = S_CRD;
      S_CRD:    state_next = S_CCHK;
      S_CCHK: begin
        if (flags.mem_bit) state_next = S_UNTAKE;
        else if (flags.node_is_root) state_next = S_DONE;
        else state_next = S_CRD;
      end
      S_UNTAKE: state_next = S_MRD;
      S_MRD:    state_next = flags.node_is_root ? S_MSET : S_MCHK;
      S_MCHK:   state_next = flags.mem_bit ? S_MRD : S_MSET;
      S_MSET:   state_next = S_DONE;
      S_DONE:   if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd.op       = OP_NONE;
    cmd.load_out = 1'b0;
    in_ready     = 1'b0;
    unique case (state)
      S_CLEAR:  cmd.op = OP_CLEAR;
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LATCH;
      end
      S_LVL: begin
        if (flags.lvl_fit) cmd.op = OP_NONE;
        else if (flags.lvl_is_one) cmd.op = OP_FAIL_SPACE;
        else cmd.op = OP_LVL_DEC;
      end
      S_SINIT:  cmd.op = OP_SCAN_INIT;
      S_SRD:    cmd.op = OP_RD_FREE;
      S_SCHK: begin
        if (flags.mem_bit) cmd.op = OP_NONE;
        else if (flags.level_end) cmd.op = flags.k_is_one ? OP_FAIL_SPACE : OP_NEXT_LEVEL;
        else cmd.op = OP_NEXT_NODE;
      end
      S_GRAB:   cmd.op = OP_GRAB;
      S_SPLIT:  if (!flags.k_at_target) cmd.op = OP_SPLIT;
      S_TAKE:   cmd.op = OP_TAKE;
      S_ADDR:   cmd.op = OP_ADDR;
      S_FCHK:   cmd.op = flags.off_outside ? OP_FAIL_FREE : OP_DIV_INIT;
      S_DIV:    cmd.op = flags.div_done ? OP_LEAF : OP_DIV_STEP;
      S_CRD:    cmd.op = OP_RD_TAKEN;
      S_CCHK: begin
        if (flags.mem_bit) cmd.op = OP_NONE;
        else cmd.op = flags.node_is_root ? OP_FAIL_FREE : OP_CLIMB;
      end
      S_UNTAKE: cmd.op = OP_UNTAKE;
      S_MRD:    if (!flags.node_is_root) cmd.op = OP_RD_BUD;
      S_MCHK:   if (flags.mem_bit) cmd.op = OP_MERGE;
      S_MSET:   cmd.op = OP_MSET;
      S_DONE:   cmd.load_out = !out_valid || out_ready;
      default:  cmd.op = OP_NONE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end
endmodule

// ----- src/bba_dp.sv -----
// Datapath of the buddy block allocator: registers, bitmap RAMs, level search,
// leaf divider and address multiplier. Depends on bba_pkg and bba_ram.
module bba_dp #(
  parameter int MAX_TREE_LEVELS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bba_pkg::CFG_W-1:0]       cfg_data,
  input  logic [bba_pkg::REQ_W-1:0]       request_bytes,
  input  logic [bba_pkg::ADDR_W-1:0]      release_address,
  input  bba_pkg::cmd_t                   cmd,
  output bba_pkg::flags_t                 flags,
  output logic [bba_pkg::STATUS_W-1:0]    status,
  output logic [bba_pkg::ADDR_W-1:0]      block_address
);
  import bba_pkg::*;

  localparam int NW    = MAX_TREE_LEVELS - 1;
  localparam int NODES = (1 << NW) - 1;
  localparam int LW    = $clog2(MAX_TREE_LEVELS);
  localparam int WW    = 37 + MAX_TREE_LEVELS;
  localparam int PW    = NW + BUCKET_W;

  logic [LEVELS_W-1:0] levels_r;
  logic [BUCKET_W-1:0] bucket_r;
  logic [ADDR_W-1:0]   base_r;

  logic [REQ_W-1:0]    req_r;
  logic [ADDR_W-1:0]   off_r;
  logic [ADDR_W-1:0]   rem;
  logic [NW-1:0]       quot;
  logic [LW-1:0]       lvl, k, cnt;
  logic [NW-1:0]       node, clr_cnt;
  logic [PW-1:0]       prod;
  logic [ADDR_W-1:0]   addr_r;
  logic [STATUS_W-1:0] stat_r;
  logic                rd_sel;

  logic [31:0]         lv_ext;
  logic [LW-1:0]       lv;
  logic [BUCKET_W-1:0] b;
  logic [WW-1:0]       div_term;
  logic [NW-1:0]       lvl_first;

  logic          free_we, free_wd, free_re, free_q;
  logic [NW-1:0] free_wa, free_ra;
  logic          taken_we, taken_wd, taken_re, taken_q;
  logic [NW-1:0] taken_wa, taken_ra;

  // Effective configuration: levels clamped to the tree, zero bucket acts as one.
  always_comb begin
    lv_ext = {28'd0, levels_r};
    if (lv_ext == 32'd0) lv_ext = 32'd1;
    if (lv_ext > 32'(MAX_TREE_LEVELS - 1)) lv_ext = 32'(MAX_TREE_LEVELS - 1);
    lv = lv_ext[LW-1:0];
    b  = (bucket_r == '0) ? BUCKET_W'(1) : bucket_r;
  end

  assign div_term  = WW'(b) << (cnt - LW'(1));
  assign lvl_first = NW'(1) << (lvl - LW'(1));

  always_comb begin
    flags.clear_done   = (clr_cnt == NW'(NODES - 1));
    flags.lvl_fit      = (req_r == '0) || ((WW'(req_r) << lvl) <= (WW'(b) << lv));
    flags.lvl_is_one   = (lvl == LW'(1));
    flags.mem_bit      = rd_sel ? taken_q : free_q;
    flags.level_end    = ((node & (node + NW'(1))) == '0);
    flags.k_is_one     = (k == LW'(1));
    flags.k_at_target  = (k == lvl);
    flags.off_outside  = WW'(off_r) >= (WW'(b) << (lv - LW'(1)));
    flags.div_done     = (cnt == '0);
    flags.node_is_root = (node == NW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      levels_r <= LEVELS_RST;
      bucket_r <= BUCKET_RST;
      base_r   <= BASE_RST;
      clr_cnt  <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_LEVELS: levels_r <= cfg_data[LEVELS_W-1:0];
          REG_BUCKET: bucket_r <= cfg_data[BUCKET_W-1:0];
          REG_BASE:   base_r   <= cfg_data[ADDR_W-1:0];
          default:    ;
        endcase
      end
      if (cmd.op == OP_CLEAR) clr_cnt <= clr_cnt + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        req_r  <= request_bytes;
        off_r  <= release_address - base_r;
        lvl    <= lv;
        addr_r <= '0;
        stat_r <= ST_OK;
      end
      OP_LVL_DEC:    lvl <= lvl - LW'(1);
      OP_FAIL_SPACE: stat_r <= ST_NO_SPACE;
      OP_FAIL_FREE:  stat_r <= ST_BAD_FREE;
      OP_SCAN_INIT: begin
        k    <= lvl;
        node <= lvl_first;
      end
      OP_RD_FREE:   rd_sel <= 1'b0;
      OP_NEXT_NODE: node <= node + NW'(1);
      OP_NEXT_LEVEL: begin
        k    <= k - LW'(1);
        node <= NW'(1) << (k - LW'(2));
      end
      OP_SPLIT: begin
        node <= node << 1;
        k    <= k + LW'(1);
      end
      OP_TAKE:  prod <= PW'(node - lvl_first) * PW'(b);
      OP_ADDR:  addr_r <= base_r + ADDR_W'(WW'(prod) << (lv - lvl));
      OP_DIV_INIT: begin
        rem  <= off_r;
        cnt  <= lv - LW'(1);
        quot <= '0;
      end
      OP_DIV_STEP: begin
        if (WW'(rem) >= div_term) begin
          rem  <= rem - ADDR_W'(div_term);
          quot <= {quot[NW-2:0], 1'b1};
        end else begin
          quot <= {quot[NW-2:0], 1'b0};
        end
        cnt <= cnt - LW'(1);
      end
      OP_LEAF:     node <= (NW'(1) << (lv - LW'(1))) | quot;
      OP_RD_TAKEN: rd_sel <= 1'b1;
      OP_CLIMB:    node <= node >> 1;
      OP_RD_BUD:   rd_sel <= 1'b0;
      OP_MERGE:    node <= node >> 1;
      default:     ;
    endcase
    if (cmd.load_out) begin
      status        <= stat_r;
      block_address <= addr_r;
    end
  end

  // Bitmap port steering; addresses are node numbers minus one.
  always_comb begin
    free_we  = 1'b0;
    free_wa  = node - NW'(1);
    free_wd  = 1'b0;
    free_re  = 1'b0;
    free_ra  = node - NW'(1);
    taken_we = 1'b0;
    taken_wa = node - NW'(1);
    taken_wd = 1'b0;
    taken_re = 1'b0;
    taken_ra = node - NW'(1);
    case (cmd.op)
      OP_CLEAR: begin
        free_we  = 1'b1;
        free_wa  = clr_cnt;
        free_wd  = (clr_cnt == '0);
        taken_we = 1'b1;
        taken_wa = clr_cnt;
      end
      OP_RD_FREE:  free_re = 1'b1;
      OP_GRAB:     free_we = 1'b1;
      OP_SPLIT: begin
        free_we = 1'b1;
        free_wa = node << 1;
        free_wd = 1'b1;
      end
      OP_TAKE: begin
        taken_we = 1'b1;
        taken_wd = 1'b1;
      end
      OP_RD_TAKEN: taken_re = 1'b1;
      OP_UNTAKE:   taken_we = 1'b1;
      OP_RD_BUD: begin
        free_re = 1'b1;
        free_ra = (node ^ NW'(1)) - NW'(1);
      end
      OP_MERGE: begin
        free_we = 1'b1;
        free_wa = (node ^ NW'(1)) - NW'(1);
      end
      OP_MSET: begin
        free_we = 1'b1;
        free_wd = 1'b1;
      end
      default: ;
    endcase
  end

  bba_ram #(.WIDTH(1), .DEPTH(NODES)) u_free_map (
    .clk(clk), .wr_en(free_we), .wr_addr(free_wa), .wr_data(free_wd),
    .rd_en(free_re), .rd_addr(free_ra), .rd_data(free_q)
  );

  bba_ram #(.WIDTH(1), .DEPTH(NODES)) u_taken_map (
    .clk(clk), .wr_en(taken_we), .wr_addr(taken_wa), .wr_data(taken_wd),
    .rd_en(taken_re), .rd_addr(taken_ra), .rd_data(taken_q)
  );
endmodule

// ----- src/buddy_block_allocator.sv -----
// Buddy block allocator: one transaction in, one result transaction out.
// An allocation fits the level, scans the free bitmap node by node, splits down to the target
// level and takes the node; a free divides the offset down to a leaf, climbs the taken bitmap
// to the taken node, clears it and merges free buddies on the way back up.
// The block works on one request at a time and takes the next only once the result is loaded.
// After reset a clearing pass writes every node of both bitmaps before requests are taken.
module buddy_block_allocator #(
  parameter int MAX_TREE_LEVELS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bba_pkg::CFG_W-1:0]     cfg_data,
  bba_req_if.sink                       request,
  bba_rsp_if.source                     result
);
  import bba_pkg::*;

  // The controller sequences each transaction; the datapath holds the bitmaps
  // in two RAMs and does the arithmetic. They talk only through cmd and flags.
  cmd_t   cmd;
  flags_t flags;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_action (request.action),
    .in_ready  (request.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  // The result register sits in the datapath, so a finished result can wait
  // for the sink while the next request is already accepted.
  bba_dp #(.MAX_TREE_LEVELS(MAX_TREE_LEVELS)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .request_bytes   (request.request_bytes),
    .release_address (request.release_address),
    .cmd             (cmd),
    .flags           (flags),
    .status          (result.status),
    .block_address   (result.block_address)
  );
endmodule

// ----- src/bba_checker.sv -----
// Port-level checks of the buddy block allocator and their bind to the top level.
// Depends on bba_pkg for the status codes.
module bba_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [bba_pkg::STATUS_W-1:0] rsp_status,
  input logic [bba_pkg::ADDR_W-1:0]   rsp_address
);
  import bba_pkg::*;

  // Reset empties the result register and starts the clearing pass.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid && !req_ready)
    else $error("result or request channel active right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_NO_SPACE ||
                   rsp_status == ST_BAD_FREE))
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_address == '0)
    else $error("failed transaction carries a nonzero address");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_address))
    else $error("stalled result changed");
endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (request.valid),
  .req_ready   (request.ready),
  .rsp_valid   (result.valid),
  .rsp_ready   (result.ready),
  .rsp_status  (result.status),
  .rsp_address (result.block_address)
);
